// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int GRAN_ORDER       = 5;
  localparam int ORD_W            = 5;
  localparam int DATA_W           = 16;
  localparam int NEED_W           = 17;
  localparam int POW_W            = 18;
  localparam int MAX_ORDER_DEF    = 16;
  localparam int HEADER_BYTES_DEF = 16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] address;
  } bba_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] granted_address;
    logic              ok;
  } bba_res_t;

  typedef struct packed {
    logic re;
    logic we_link;
    logic we_order;
  } bba_mem_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORDER,
    S_SEARCH,
    S_POP,
    S_SPLIT,
    S_FREE_ADR,
    S_FREE_TAG
  } bba_state_t;

endpackage

// ===== hw/rtl/bba_gran_mem.sv =====
// ----------------------------------------------------------------------------
// bba_gran_mem
// Per-granule link and order tag store, one port, registered read.
// ----------------------------------------------------------------------------
module bba_gran_mem #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bba_pkg::bba_mem_ctl_t      ctl,
  input  logic [MAX_ORDER-bba_pkg::GRAN_ORDER-1:0] addr,
  input  logic [MAX_ORDER-bba_pkg::GRAN_ORDER:0]   link_wdata,
  input  logic [bba_pkg::ORD_W-1:0]  order_wdata,
  output logic [MAX_ORDER-bba_pkg::GRAN_ORDER:0]   link_rdata,
  output logic [bba_pkg::ORD_W-1:0]  order_rdata
);

  localparam int IW    = MAX_ORDER - bba_pkg::GRAN_ORDER;
  localparam int NGRAN = 1 << IW;

  logic [IW:0]               link_mem  [NGRAN];
  logic [bba_pkg::ORD_W-1:0] order_mem [NGRAN];
  logic [IW:0]               link_q;
  logic [bba_pkg::ORD_W-1:0] order_q;
  logic                      link0_set;
  logic                      order0_set;
  logic                      link_dflt;
  logic                      order_dflt;

  always_ff @(posedge clk) begin
    if (ctl.we_link) begin
      link_mem[addr] <= link_wdata;
    end
    if (ctl.we_order) begin
      order_mem[addr] <= order_wdata;
    end
    if (ctl.re) begin
      link_q  <= link_mem[addr];
      order_q <= order_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link0_set  <= 1'b0;
      order0_set <= 1'b0;
      link_dflt  <= 1'b0;
      order_dflt <= 1'b0;
    end else begin
      if (ctl.we_link && addr == '0) begin
        link0_set <= 1'b1;
      end
      if (ctl.we_order && addr == '0) begin
        order0_set <= 1'b1;
      end
      if (ctl.re) begin
        link_dflt  <= (addr == '0) && !link0_set;
        order_dflt <= (addr == '0) && !order0_set;
      end
    end
  end

  assign link_rdata  = link_dflt  ? (IW+1)'(NGRAN) : link_q;
  assign order_rdata = order_dflt ? bba_pkg::ORD_W'(MAX_ORDER) : order_q;

endmodule

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator with one LIFO free list per order, no coalescing.
// ----------------------------------------------------------------------------
// Allocate: sizes the order, scans the lists upward, pops the found block
//   and splits it down to the order, all through the single-port granule store.
// Free: checks the address, then checks the order tag and pushes the block;
//   stops after the address check when the address is rejected.
// One item at a time; busy while working.
// Reset: top-order list holds block zero, all other lists empty.
// The result strobe is never stalled.
module buddy_block_allocator_core #(
  parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
  parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bba_pkg::bba_cmd_t cmd,
  output logic              done,
  output bba_pkg::bba_res_t result
);

  localparam int GR    = bba_pkg::GRAN_ORDER;
  localparam int IW    = MAX_ORDER - GR;
  localparam int NGRAN = 1 << IW;
  localparam int LW    = $clog2(MAX_ORDER + 1);
  localparam int SW    = ((MAX_ORDER > bba_pkg::DATA_W) ? MAX_ORDER : bba_pkg::DATA_W) + 1;

  bba_pkg::bba_state_t state, state_next;

  logic [IW:0]                 list_head [MAX_ORDER+1];
  logic [bba_pkg::NEED_W-1:0]  need;
  logic                        req_zero;
  logic [bba_pkg::POW_W-1:0]   pow;
  logic [LW-1:0]               ord;
  logic [LW-1:0]               i_cur;
  logic [IW-1:0]               blk;
  logic [bba_pkg::DATA_W-1:0]  addr_r;

  bba_pkg::bba_mem_ctl_t       mem_ctl;
  logic [IW-1:0]               mem_addr;
  logic [IW:0]                 mem_link_wdata;
  logic [bba_pkg::ORD_W-1:0]   mem_order_wdata;
  logic [IW:0]                 link_rdata;
  logic [bba_pkg::ORD_W-1:0]   order_rdata;

  logic [LW-1:0]               i_dec;
  logic [LW-1:0]               head_ridx;
  logic [IW:0]                 head_rd;
  logic                        head_we;
  logic [LW-1:0]               head_widx;
  logic [IW:0]                 head_wdata;

  logic [SW-1:0]               off;
  logic                        adr_bad;
  logic [bba_pkg::ORD_W-1:0]   tag_sh;
  logic [IW-1:0]               tag_mask;
  logic                        tag_bad;
  logic [IW-1:0]               split_idx;
  logic [SW-1:0]               grant_sum;

  logic                        fin;
  logic                        fin_ok;
  logic [bba_pkg::DATA_W-1:0]  fin_addr;

  bba_gran_mem #(
    .MAX_ORDER(MAX_ORDER)
  ) u_gran_mem (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mem_ctl),
    .addr        (mem_addr),
    .link_wdata  (mem_link_wdata),
    .order_wdata (mem_order_wdata),
    .link_rdata  (link_rdata),
    .order_rdata (order_rdata)
  );

  assign busy  = (state != bba_pkg::S_IDLE);
  assign i_dec = i_cur - LW'(1);

  assign off       = SW'(addr_r) - SW'(HEADER_BYTES);
  assign adr_bad   = (SW'(addr_r) < SW'(HEADER_BYTES)) || (off[GR-1:0] != '0)
                     || (off[SW-1:MAX_ORDER] != '0);
  assign tag_sh    = order_rdata - bba_pkg::ORD_W'(GR);
  assign tag_mask  = ~({IW{1'b1}} << tag_sh);
  assign tag_bad   = (order_rdata < bba_pkg::ORD_W'(GR))
                     || (order_rdata > bba_pkg::ORD_W'(MAX_ORDER))
                     || ((blk & tag_mask) != '0);
  assign split_idx = blk + (IW'(1) << (i_dec - LW'(GR)));
  assign grant_sum = SW'({blk, {GR{1'b0}}}) + SW'(HEADER_BYTES);

  always_comb begin
    unique case (state)
      bba_pkg::S_SPLIT:    head_ridx = i_dec;
      bba_pkg::S_FREE_TAG: head_ridx = order_rdata[LW-1:0];
      default:             head_ridx = i_cur;
    endcase
  end

  assign head_rd = list_head[head_ridx];

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::S_IDLE: begin
        if (start) begin
          state_next = (cmd.mode == bba_pkg::MODE_FREE) ? bba_pkg::S_FREE_ADR
                                                        : bba_pkg::S_ORDER;
        end
      end
      bba_pkg::S_ORDER: begin
        priority if (req_zero) begin
          state_next = bba_pkg::S_IDLE;
        end else if (pow >= bba_pkg::POW_W'(need)) begin
          state_next = bba_pkg::S_SEARCH;
        end else if (ord == LW'(MAX_ORDER)) begin
          state_next = bba_pkg::S_IDLE;
        end else begin
          state_next = bba_pkg::S_ORDER;
        end
      end
      bba_pkg::S_SEARCH: begin
        priority if (!head_rd[IW]) begin
          state_next = bba_pkg::S_POP;
        end else if (i_cur == LW'(MAX_ORDER)) begin
          state_next = bba_pkg::S_IDLE;
        end else begin
          state_next = bba_pkg::S_SEARCH;
        end
      end
      bba_pkg::S_POP:      state_next = bba_pkg::S_SPLIT;
      bba_pkg::S_SPLIT: begin
        if (i_cur <= ord) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_FREE_ADR: state_next = adr_bad ? bba_pkg::S_IDLE : bba_pkg::S_FREE_TAG;
      bba_pkg::S_FREE_TAG: state_next = bba_pkg::S_IDLE;
      default:             state_next = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl         = '0;
    mem_addr        = blk;
    mem_link_wdata  = head_rd;
    mem_order_wdata = bba_pkg::ORD_W'(i_dec);
    head_we         = 1'b0;
    head_widx       = i_cur;
    head_wdata      = link_rdata[IW] ? (IW+1)'(NGRAN) : link_rdata;
    fin             = 1'b0;
    fin_ok          = 1'b0;
    fin_addr        = '0;
    unique case (state)
      bba_pkg::S_ORDER: begin
        if (req_zero || (pow < bba_pkg::POW_W'(need) && ord == LW'(MAX_ORDER))) begin
          fin = 1'b1;
        end
      end
      bba_pkg::S_SEARCH: begin
        if (!head_rd[IW]) begin
          mem_ctl.re = 1'b1;
          mem_addr   = head_rd[IW-1:0];
        end else if (i_cur == LW'(MAX_ORDER)) begin
          fin = 1'b1;
        end
      end
      bba_pkg::S_POP: begin
        head_we = 1'b1;
      end
      bba_pkg::S_SPLIT: begin
        if (i_cur > ord) begin
          mem_ctl.we_link  = 1'b1;
          mem_ctl.we_order = 1'b1;
          mem_addr         = split_idx;
          head_we          = 1'b1;
          head_widx        = i_dec;
          head_wdata       = {1'b0, split_idx};
        end else begin
          mem_ctl.we_order = 1'b1;
          mem_order_wdata  = bba_pkg::ORD_W'(ord);
          fin              = 1'b1;
          fin_ok           = 1'b1;
          fin_addr         = grant_sum[bba_pkg::DATA_W-1:0];
        end
      end
      bba_pkg::S_FREE_ADR: begin
        if (adr_bad) begin
          fin = 1'b1;
        end else begin
          mem_ctl.re = 1'b1;
          mem_addr   = off[MAX_ORDER-1:GR];
        end
      end
      bba_pkg::S_FREE_TAG: begin
        fin = 1'b1;
        if (!tag_bad) begin
          mem_ctl.we_link  = 1'b1;
          mem_ctl.we_order = 1'b1;
          mem_order_wdata  = order_rdata;
          head_we          = 1'b1;
          head_widx        = order_rdata[LW-1:0];
          head_wdata       = {1'b0, blk};
          fin_ok           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_IDLE;
      done  <= 1'b0;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        list_head[k] <= (k == MAX_ORDER) ? '0 : (IW+1)'(NGRAN);
      end
    end else begin
      state <= state_next;
      done  <= fin;
      if (head_we) begin
        list_head[head_widx] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result.ok              <= fin_ok;
      result.granted_address <= fin_addr;
    end
    unique case (state)
      bba_pkg::S_IDLE: begin
        need     <= bba_pkg::NEED_W'(cmd.request_size) + bba_pkg::NEED_W'(HEADER_BYTES);
        req_zero <= (cmd.request_size == '0);
        ord      <= LW'(GR);
        pow      <= bba_pkg::POW_W'(1) << GR;
        addr_r   <= cmd.address;
      end
      bba_pkg::S_ORDER: begin
        if (pow >= bba_pkg::POW_W'(need)) begin
          i_cur <= ord;
        end else begin
          ord <= ord + LW'(1);
          pow <= pow << 1;
        end
      end
      bba_pkg::S_SEARCH: begin
        if (!head_rd[IW]) begin
          blk <= head_rd[IW-1:0];
        end else begin
          i_cur <= i_cur + LW'(1);
        end
      end
      bba_pkg::S_SPLIT: begin
        if (i_cur > ord) begin
          i_cur <= i_dec;
        end
      end
      bba_pkg::S_FREE_ADR: begin
        blk <= off[MAX_ORDER-1:GR];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator command and result timing.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input bba_pkg::bba_cmd_t cmd,
  input logic              done,
  input bba_pkg::bba_res_t result
);

  logic cmd_seen;

  assign cmd_seen = cmd.mode || !cmd.mode;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd_seen) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_on_fall: assert property (@(posedge clk) disable iff (rst)
    done == $fell(busy))
    else $error("result strobe not aligned with end of busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.granted_address == '0))
    else $error("failed item returned a nonzero address");

  a_idle_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);

// ===== test/bba_grant_monitor.sv =====
// ----------------------------------------------------------------------------
// bba_grant_monitor
// Watches the command and result channels of the buddy block allocator,
// keeps its own copy of the per-order free lists and granule order tags,
// predicts the result of every accepted item and compares results in order.
// ----------------------------------------------------------------------------
module bba_grant_monitor #(
  parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
  parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF,
  parameter int NGRAN        = 1 << (MAX_ORDER - bba_pkg::GRAN_ORDER)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  bba_pkg::bba_cmd_t cmd,
  input  logic              done,
  input  bba_pkg::bba_res_t result,
  output int                errors,
  output int                outstanding,
  output logic [NGRAN-1:0]  tag_known
);
  import bba_pkg::*;

  localparam int LINK_W = MAX_ORDER - GRAN_ORDER + 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NGRAN);
  localparam int SHOW_MAX = 200;

  logic [LINK_W-1:0] free_head [0:MAX_ORDER];
  logic [LINK_W-1:0] free_next [0:NGRAN-1];
  logic [ORD_W-1:0]  blk_order [0:NGRAN-1];
  bba_res_t          pending_grants [$];
  int                shown = 0;

  function automatic void push_free(input int idx, input int ord);
    int g;
    g = idx & (NGRAN - 1);
    blk_order[g] = ORD_W'(ord);
    tag_known[g] = 1'b1;
    free_next[g] = free_head[ord];
    free_head[ord] = LINK_W'(g);
  endfunction

  function automatic bba_res_t grant_for(input bba_cmd_t c);
    bba_res_t r;
    int need, ord, src, blk, addr, off, idx, t;
    r = '0;
    if (c.mode == MODE_ALLOC) begin
      if (c.request_size != '0) begin
        need = int'(c.request_size) + HEADER_BYTES;
        ord = GRAN_ORDER;
        while (ord < 31 && (1 << ord) < need) ord++;
        src = -1;
        if (ord <= MAX_ORDER) begin
          for (int j = ord; j <= MAX_ORDER; j++) begin
            if (src < 0 && free_head[j] < NIL) src = j;
          end
        end
        if (src >= 0) begin
          blk = int'(free_head[src]);
          free_head[src] = (free_next[blk] < NIL) ? free_next[blk] : NIL;
          for (int k = src - 1; k >= ord; k--) begin
            push_free(blk + (1 << (k - GRAN_ORDER)), k);
          end
          blk_order[blk] = ORD_W'(ord);
          tag_known[blk] = 1'b1;
          r.granted_address = DATA_W'((blk << GRAN_ORDER) + HEADER_BYTES);
          r.ok = 1'b1;
        end
      end
    end else begin
      addr = int'(c.address);
      if (addr != 0 && addr >= HEADER_BYTES) begin
        off = addr - HEADER_BYTES;
        idx = off >> GRAN_ORDER;
        if ((off & ((1 << GRAN_ORDER) - 1)) == 0 && idx < NGRAN) begin
          t = int'(blk_order[idx]);
          if (t >= GRAN_ORDER && t <= MAX_ORDER &&
              (idx & ((1 << (t - GRAN_ORDER)) - 1)) == 0) begin
            push_free(idx, t);
            r.ok = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bba_res_t want;
    if (rst) begin
      for (int g = 0; g < NGRAN; g++) begin
        free_next[g] = NIL;
        blk_order[g] = '0;
      end
      for (int o = 0; o <= MAX_ORDER; o++) free_head[o] = NIL;
      free_head[MAX_ORDER] = '0;
      blk_order[0] = ORD_W'(MAX_ORDER);
      tag_known = '0;
      tag_known[0] = 1'b1;
      pending_grants.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (pending_grants.size() == 0) begin
          errors++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("%0t: unexpected result, expected none, actual %h/%b",
                     $time, result.granted_address, result.ok);
          end
        end else begin
          want = pending_grants.pop_front();
          if (result.granted_address != want.granted_address ||
              result.ok != want.ok) begin
            errors++;
            if (shown < SHOW_MAX && result.granted_address != want.granted_address) begin
              shown++;
              $display("%0t: granted_address expected %h actual %h",
                       $time, want.granted_address, result.granted_address);
            end
            if (shown < SHOW_MAX && result.ok != want.ok) begin
              shown++;
              $display("%0t: ok expected %b actual %b", $time, want.ok, result.ok);
            end
          end
        end
      end
      if (start && !busy) pending_grants.push_back(grant_for(cmd));
    end
    outstanding = pending_grants.size();
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the buddy block allocator: a directed pass over the size and
// address extremes, splitting, failing requests and ignored frees, then
// random allocate/free traffic built mostly from live grants, with random
// idle gaps. Prediction and comparison live in bba_grant_monitor.
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;

  localparam int NGRAN      = 1 << (MAX_ORDER_DEF - GRAN_ORDER);
  localparam int WATCHDOG   = 5000;
  localparam int RAND_ITEMS = 1925;
  localparam int DRAIN      = 3 * MAX_ORDER_DEF + 10;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  bba_cmd_t         cmd   = '0;
  logic             busy;
  logic             done;
  bba_res_t         result;
  int               errors;
  int               outstanding;
  logic [NGRAN-1:0] tag_known;
  logic [DATA_W-1:0] live_q [$];
  logic [DATA_W-1:0] freed_q [$];
  int               idle_cycles = 0;
  int               sent;
  bit               noise_item;

  always #5 clk = ~clk;

  buddy_block_allocator_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  bba_grant_monitor mon (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding),
    .tag_known   (tag_known)
  );

  always @(posedge clk) begin
    if (!rst && done && result.ok && result.granted_address != '0)
      live_q.push_back(result.granted_address);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bba_cmd_t mk(input logic m, input int sz, input int ad);
    bba_cmd_t c;
    c.mode = m;
    c.request_size = DATA_W'(sz);
    c.address = DATA_W'(ad);
    return c;
  endfunction

  function automatic bit free_safe(input logic [DATA_W-1:0] a);
    int off;
    off = int'(a) - HEADER_BYTES_DEF;
    return (off < 0) || ((off & ((1 << GRAN_ORDER) - 1)) != 0) ||
           tag_known[off >> GRAN_ORDER];
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((sent / 150) % 4 == 2) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 100);
  endfunction

  function automatic bba_cmd_t next_item();
    bba_cmd_t c;
    int roll, thr, e2, pos;
    c.mode = MODE_ALLOC;
    c.request_size = DATA_W'($urandom);
    c.address = DATA_W'($urandom);
    noise_item = 1'b0;
    roll = $urandom_range(0, 99);
    thr = (live_q.size() > 40) ? 30 : 50;
    if (roll < thr) begin
      e2 = $urandom_range(0, 16);
      if (e2 < 16) c.request_size = DATA_W'($urandom_range(1, 1 << e2));
      if ($urandom_range(0, 49) == 0) begin
        case ($urandom_range(0, 3))
          0: c.request_size = '0;
          1: c.request_size = '1;
          2: c.request_size = DATA_W'(65520);
          default: c.request_size = DATA_W'(1);
        endcase
      end
    end else if (roll < 93 && live_q.size() > 0) begin
      pos = $urandom_range(0, live_q.size() - 1);
      c.mode = MODE_FREE;
      c.address = live_q[pos];
      live_q.delete(pos);
      freed_q.push_back(c.address);
      if (freed_q.size() > 16) void'(freed_q.pop_front());
    end else if (roll < 94 && freed_q.size() > 0) begin
      c.mode = MODE_FREE;
      c.address = freed_q[$urandom_range(0, freed_q.size() - 1)];
    end else begin
      c.mode = MODE_FREE;
      if (!free_safe(c.address)) c.address[0] = ~c.address[0];
      noise_item = 1'b1;
    end
    return c;
  endfunction

  task automatic send(input bba_cmd_t c, input bit pick, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    if (pick) c = next_item();
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(mk(MODE_ALLOC, 0,     16'hFFFF), 0, 0);
    send(mk(MODE_ALLOC, 65535, 0),        0, 0);
    send(mk(MODE_ALLOC, 65520, 16'hAAAA), 0, 1);
    send(mk(MODE_ALLOC, 1,     0),        0, 0);
    send(mk(MODE_FREE,  16'hFFFF, 16),    0, 0);
    send(mk(MODE_FREE,  0,     0),        0, 2);
    send(mk(MODE_FREE,  16'h5555, 15),    0, 0);
    send(mk(MODE_FREE,  0,     17),       0, 0);
    send(mk(MODE_ALLOC, 1,     16'hFFFF), 0, 0);
    send(mk(MODE_ALLOC, 16,    0),        0, 1);
    send(mk(MODE_ALLOC, 17,    0),        0, 0);
    send(mk(MODE_ALLOC, 32768, 0),        0, 0);
    send(mk(MODE_ALLOC, 16368, 0),        0, 3);
    send(mk(MODE_FREE,  0,     48),       0, 0);
    send(mk(MODE_FREE,  0,     16400),    0, 0);
    send(mk(MODE_FREE,  0,     16400),    0, 0);
    send(mk(MODE_ALLOC, 16368, 0),        0, 0);
    send(mk(MODE_ALLOC, 1,     0),        0, 1);
    send(mk(MODE_FREE,  16'hFFFF, 65535), 0, 0);
    send(mk(MODE_FREE,  0,     80),       0, 0);
    send(mk(MODE_ALLOC, 20000, 0),        0, 0);
    send(mk(MODE_FREE,  0,     32784),    0, 2);
    send(mk(MODE_ALLOC, 65520, 0),        0, 0);

    while (sent < RAND_ITEMS) begin
      if (!paused && sent == RAND_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      send('0, 1, rand_gap());
      if (!noise_item) sent++;
    end

    drain();
    repeat (DRAIN) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
